FILE: rtl/sccd_pkg.sv
`default_nettype none

package sccd_pkg;

   // Frame geometry
   localparam int unsigned FRAME_BYTES = 20;
   localparam int unsigned POS_W       = 5;

   typedef logic [POS_W-1:0] pos_type;

   localparam pos_type POS_HUNT     = 5'd0;
   localparam pos_type POS_HDR2     = 5'd1;
   localparam pos_type POS_TYPE     = 5'd2;
   localparam pos_type POS_CRC_LAST = 5'd17;
   localparam pos_type POS_CHK_LO   = 5'd18;
   localparam pos_type POS_LAST     = 5'd19;

   // Byte codes
   localparam logic [7:0] HDR_FIRST  = 8'hAA;
   localparam logic [7:0] HDR_SECOND = 8'h55;
   localparam logic [7:0] TYPE_OK    = 8'h01;

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Decoded frame; the first field sits in the highest bits.
   typedef struct packed {
      logic signed [7:0]  hat_vertical;
      logic signed [7:0]  hat_horizontal;
      logic [7:0]         right_trigger;
      logic [7:0]         left_trigger;
      logic signed [15:0] right_y;
      logic signed [15:0] right_x;
      logic signed [15:0] left_y;
      logic signed [15:0] left_x;
      logic [15:0]        buttons;
      logic [7:0]         sequence_res;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);

endpackage

`default_nettype wire

FILE: rtl/sccd_crc16.sv
`default_nettype none

module sccd_crc16 (
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data,
   output logic [15:0]      crc_next
);
   import sccd_pkg::*;

   // One reflected byte update, one bit per step.
   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

FILE: rtl/sccd_parser.sv
`default_nettype none

module sccd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          rx_byte,
   output logic                     frame_good,
   output sccd_pkg::result_type     frame_data
);
   import sccd_pkg::*;

   pos_type     pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_upd;
   logic [7:0]  store_ff [POS_TYPE:POS_CHK_LO];

   sccd_crc16 u_crc (
      .crc_cur  (crc_ff),
      .data     (rx_byte),
      .crc_next (crc_upd)
   );

   // Header hunt and frame position.
   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (step) begin
         priority if (pos_ff == POS_HUNT) begin
            pos_in = (rx_byte == HDR_FIRST) ? POS_HDR2 : POS_HUNT;
         end else if (pos_ff == POS_HDR2) begin
            if (rx_byte == HDR_SECOND) begin
               pos_in = POS_TYPE;
               crc_in = CRC_INIT;
            end else if (rx_byte == HDR_FIRST) begin
               pos_in = POS_HDR2;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_LAST) begin
            pos_in = POS_HUNT;
         end else begin
            pos_in = pos_ff + 5'd1;
            if (pos_ff <= POS_CRC_LAST) begin
               crc_in = crc_upd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // Frame bytes 2 to 18 each land in their own register.
   always_ff @(posedge clock) begin
      if (step && pos_ff >= POS_TYPE && pos_ff <= POS_CHK_LO) begin
         store_ff[pos_ff] <= rx_byte;
      end
   end

   // The last byte completes the check word.
   assign frame_good = step && (pos_ff == POS_LAST) && (store_ff[POS_TYPE] == TYPE_OK)
                       && (crc_ff == {rx_byte, store_ff[POS_CHK_LO]});

   always_comb begin
      frame_data.sequence_res   = store_ff[3];
      frame_data.buttons        = {store_ff[5], store_ff[4]};
      frame_data.left_x         = {store_ff[7], store_ff[6]};
      frame_data.left_y         = {store_ff[9], store_ff[8]};
      frame_data.right_x        = {store_ff[11], store_ff[10]};
      frame_data.right_y        = {store_ff[13], store_ff[12]};
      frame_data.left_trigger   = store_ff[14];
      frame_data.right_trigger  = store_ff[15];
      frame_data.hat_horizontal = store_ff[16];
      frame_data.hat_vertical   = store_ff[17];
   end

   // The position never leaves the frame.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < pos_type'(FRAME_BYTES))
      else $error("frame position out of range");

   // A completed header always restarts the CRC.
   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      (step && pos_ff == POS_HDR2 && rx_byte == HDR_SECOND) |=>
      (crc_ff == CRC_INIT && pos_ff == POS_TYPE))
      else $error("CRC not restarted after header");

   // After the last byte the parser hunts again.
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (step && pos_ff == POS_LAST) |=> (pos_ff == POS_HUNT))
      else $error("parser did not return to hunting");

endmodule

`default_nettype wire

FILE: rtl/sync_crc_frame_decoder.sv
`default_nettype none

// Framed packet decoder with a CRC-16/MODBUS check. Each request carries one
// received serial byte; the block finds the 0xAA 0x55 header, collects a
// 20-byte frame, and for a frame whose type byte is 0x01 and whose CRC over
// bytes 2 to 17 matches the little-endian word in bytes 18 and 19 it emits
// one response with the decoded controller fields. Bad frames are dropped
// silently. A byte is taken every cycle while the response side does not stall:
// it passes an input register, then the header tracker and byte-wide CRC update,
// and a good frame lands in the response register as its last byte leaves the input register.
// Back-pressure on the response side stalls the byte stream only while a
// finished response is still waiting.

module sync_crc_frame_decoder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [7:0] sequence_res, [23:8] buttons, [39:24] left_x, [55:40] left_y,
   // [71:56] right_x, [87:72] right_y, [95:88] left_trigger,
   // [103:96] right_trigger, [111:104] hat_horizontal, [119:112] hat_vertical
   output logic [119:0]      rsp_tdata
);
   import sccd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       step;
   logic       frame_good;
   result_type frame_data;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // The pipeline moves unless a response is stuck.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   sccd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .frame_good (frame_good),
      .frame_data (frame_data)
   );

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame_good) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_good) begin
         rsp_data_ff <= frame_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A waiting response is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !frame_good)
      else $error("response overwritten while stalled");

   // A held byte is not lost while the pipeline is stalled.
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held byte dropped during stall");

   // A response appears only after a byte was processed.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step))
      else $error("response without a processed byte");

endmodule

`default_nettype wire

FILE: tb/sync_crc_frame_decoder_tb.sv
`timescale 1ns / 1ps

module sync_crc_frame_decoder_tb;
   import sccd_pkg::*;

   // One planned request byte; hold_for_drain pauses the sender before it
   // until every decoded frame already due has come out.
   typedef struct {
      logic [7:0] rx_byte;
      bit         hold_for_drain;
   } rx_slot_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;

   rx_slot_type  rx_stream[$];
   result_type   decoded_frames_due[$];

   // Frame under construction for the stimulus.
   logic [7:0]   draft [FRAME_BYTES];
   int unsigned  good_frames_planned = 0;

   // Decoder state mirrored by the testbench.
   pos_type      hunt_pos = POS_HUNT;
   logic [7:0]   frame_bytes [FRAME_BYTES];
   logic [15:0]  frame_crc = CRC_INIT;

   int unsigned  mismatch_count = 0;
   int unsigned  bytes_accepted = 0;
   bit           req_taken = 1'b0;

   int unsigned  tx_gap_left = 0;
   int unsigned  tx_calm_left = 0;
   int unsigned  rx_stall_left = 0;
   int unsigned  rx_calm_left = 0;
   int unsigned  rx_hold_left = 0;
   bit           rx_hold_done = 1'b0;

   sync_crc_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A generous ceiling on the whole run.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, want %h", name, got, want));
   endtask

   // Byte-wide CRC-16/MODBUS update, LSB first.
   function automatic logic [15:0] crc_modbus_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Advances the mirrored decoder by one byte. Returns 1 when the byte
   // closes a good frame, with the decoded fields in frame.
   function automatic bit decode_rx_byte(input logic [7:0] b, output result_type frame);
      pos_type p;
      p = hunt_pos;
      frame = '0;
      if (p >= FRAME_BYTES)
         p = POS_HUNT;
      if (p == POS_HUNT) begin
         hunt_pos = (b == HDR_FIRST) ? POS_HDR2 : POS_HUNT;
         return 1'b0;
      end
      if (p == POS_HDR2) begin
         if (b == HDR_SECOND) begin
            frame_crc = CRC_INIT;
            hunt_pos  = POS_TYPE;
         end else if (b == HDR_FIRST) begin
            hunt_pos = POS_HDR2;
         end else begin
            hunt_pos = POS_HUNT;
         end
         return 1'b0;
      end
      // Frame body: no header check here, the frame always runs full length.
      frame_bytes[p] = b;
      if (p <= POS_CRC_LAST)
         frame_crc = crc_modbus_byte(frame_crc, b);
      if (p != POS_LAST) begin
         hunt_pos = p + 5'd1;
         return 1'b0;
      end
      hunt_pos = POS_HUNT;
      if (frame_bytes[POS_TYPE] != TYPE_OK)
         return 1'b0;
      if (frame_crc != {frame_bytes[POS_LAST], frame_bytes[POS_CHK_LO]})
         return 1'b0;
      frame.sequence_res   = frame_bytes[3];
      frame.buttons        = {frame_bytes[5], frame_bytes[4]};
      frame.left_x         = {frame_bytes[7], frame_bytes[6]};
      frame.left_y         = {frame_bytes[9], frame_bytes[8]};
      frame.right_x        = {frame_bytes[11], frame_bytes[10]};
      frame.right_y        = {frame_bytes[13], frame_bytes[12]};
      frame.left_trigger   = frame_bytes[14];
      frame.right_trigger  = frame_bytes[15];
      frame.hat_horizontal = frame_bytes[16];
      frame.hat_vertical   = frame_bytes[17];
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_byte(input logic [7:0] b, input bit hold_for_drain = 1'b0);
      rx_slot_type slot;
      slot.rx_byte        = b;
      slot.hold_for_drain = hold_for_drain;
      rx_stream.push_back(slot);
   endtask

   task automatic fill_draft_random();
      draft[0] = HDR_FIRST;
      draft[1] = HDR_SECOND;
      draft[POS_TYPE] = TYPE_OK;
      for (int i = 3; i <= POS_CRC_LAST; i++)
         draft[i] = 8'($urandom_range(0, 255));
   endtask

   task automatic set_draft_fields(input logic [7:0] seq, input logic [15:0] btn,
                                   input logic [15:0] lx, input logic [15:0] ly,
                                   input logic [15:0] rx, input logic [15:0] ry,
                                   input logic [7:0] lt, input logic [7:0] rt,
                                   input logic [7:0] hh, input logic [7:0] hv);
      draft[3]  = seq;
      draft[4]  = btn[7:0];
      draft[5]  = btn[15:8];
      draft[6]  = lx[7:0];
      draft[7]  = lx[15:8];
      draft[8]  = ly[7:0];
      draft[9]  = ly[15:8];
      draft[10] = rx[7:0];
      draft[11] = rx[15:8];
      draft[12] = ry[7:0];
      draft[13] = ry[15:8];
      draft[14] = lt;
      draft[15] = rt;
      draft[16] = hh;
      draft[17] = hv;
   endtask

   // Appends the check word (optionally corrupted in one bit) and queues the frame.
   task automatic queue_draft(input bit bad_crc, input bit hold_for_drain = 1'b0);
      logic [15:0] crc;
      crc = CRC_INIT;
      for (int i = POS_TYPE; i <= POS_CRC_LAST; i++)
         crc = crc_modbus_byte(crc, draft[i]);
      if (bad_crc)
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      draft[POS_CHK_LO] = crc[7:0];
      draft[POS_LAST]   = crc[15:8];
      for (int i = 0; i < FRAME_BYTES; i++)
         push_byte(draft[i], hold_for_drain && (i == 0));
   endtask

   // Request side: a new byte goes out only once the previous one was taken.
   always @(negedge clock) begin
      rx_slot_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // Keep offering the same byte.
      end else if (tx_gap_left > 0) begin
         tx_gap_left--;
         req_tvalid <= 1'b0;
      end else if (rx_stream.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (rx_stream[0].hold_for_drain && decoded_frames_due.size() != 0) begin
         req_tvalid <= 1'b0;
      end else begin
         head = rx_stream.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= head.rx_byte;
         if (tx_calm_left > 0) begin
            tx_calm_left--;
            tx_gap_left = 0;
         end else begin
            tx_gap_left = pick_gap();
            if ($urandom_range(0, 63) == 0)
               tx_calm_left = $urandom_range(40, 150);
         end
      end
   end

   // Response side: random stalls, calm stretches, and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else if (!rx_hold_done && bytes_accepted >= 400) begin
         rx_hold_done = 1'b1;
         rx_hold_left = 300;
         rsp_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_calm_left > 0) begin
            rx_calm_left--;
         end else begin
            rx_stall_left = pick_gap();
            if ($urandom_range(0, 63) == 0)
               rx_calm_left = $urandom_range(40, 150);
         end
      end
   end

   // Both handshakes are observed at the rising edge.
   always @(posedge clock) begin
      result_type fresh;
      result_type got;
      result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            bytes_accepted++;
            if (decode_rx_byte(req_tdata, fresh))
               decoded_frames_due.push_back(fresh);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (decoded_frames_due.size() == 0) begin
               report_mismatch($sformatf("response with no frame due: %h", rsp_tdata));
            end else begin
               want = decoded_frames_due.pop_front();
               check_field("sequence_res", 16'(got.sequence_res),
                           16'(want.sequence_res));
               check_field("buttons", got.buttons, want.buttons);
               check_field("left_x", got.left_x, want.left_x);
               check_field("left_y", got.left_y, want.left_y);
               check_field("right_x", got.right_x, want.right_x);
               check_field("right_y", got.right_y, want.right_y);
               check_field("left_trigger", 16'(got.left_trigger),
                           16'(want.left_trigger));
               check_field("right_trigger", 16'(got.right_trigger),
                           16'(want.right_trigger));
               check_field("hat_horizontal", 16'(got.hat_horizontal),
                           16'(want.hat_horizontal));
               check_field("hat_vertical", 16'(got.hat_vertical),
                           16'(want.hat_vertical));
            end
         end
      end
   end

   // Stimulus plan and end of run.
   initial begin
      int unsigned roll;
      int unsigned n;
      logic [7:0]  b;
      bit          mid_drain_done;
      mid_drain_done = 1'b0;

      // Hunting ignores anything but the first header byte.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(HDR_SECOND);
      push_byte(8'h5A);

      // Field minimums and signed extremes at the low end.
      fill_draft_random();
      set_draft_fields(8'h00, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                       8'h00, 8'h00, 8'h80, 8'h80);
      queue_draft(1'b0);

      // Repeated first header byte keeps the header alive; field maximums.
      push_byte(HDR_FIRST);
      push_byte(HDR_FIRST);
      fill_draft_random();
      set_draft_fields(8'hFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                       8'hFF, 8'hFF, 8'h7F, 8'h7F);
      queue_draft(1'b0);

      // A bad second header byte drops back to hunting.
      push_byte(HDR_FIRST);
      push_byte(8'h12);
      push_byte(HDR_SECOND);
      fill_draft_random();
      set_draft_fields(8'h00, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                       8'h00, 8'hFF, 8'h00, 8'hFF);
      queue_draft(1'b0);

      // Wrong type bytes with a consistent check word are dropped.
      fill_draft_random();
      draft[POS_TYPE] = 8'h02;
      queue_draft(1'b0);
      fill_draft_random();
      draft[POS_TYPE] = 8'hFF;
      queue_draft(1'b0);
      fill_draft_random();
      draft[POS_TYPE] = 8'h00;
      queue_draft(1'b0);

      // Check word mismatch is dropped.
      fill_draft_random();
      queue_draft(1'b1);

      // Header bytes inside the payload are plain data.
      fill_draft_random();
      draft[3] = HDR_FIRST;
      draft[4] = HDR_SECOND;
      draft[5] = HDR_FIRST;
      draft[17] = HDR_FIRST;
      queue_draft(1'b0);

      // Back-to-back good frames, the first one after a full drain.
      fill_draft_random();
      queue_draft(1'b0, 1'b1);
      fill_draft_random();
      queue_draft(1'b0);

      // Random part: mostly well-formed frames, some broken ones and noise.
      while (rx_stream.size() < 1900 || good_frames_planned < 60) begin
         roll = $urandom_range(0, 99);
         fill_draft_random();
         if (roll < 65) begin
            queue_draft(1'b0, !mid_drain_done && rx_stream.size() > 950);
            if (rx_stream.size() > 950)
               mid_drain_done = 1'b1;
            good_frames_planned++;
         end else if (roll < 75) begin
            do
               b = 8'($urandom_range(0, 255));
            while (b == TYPE_OK);
            draft[POS_TYPE] = b;
            queue_draft(1'b0);
         end else if (roll < 85) begin
            queue_draft(1'b1);
         end else if (roll < 92) begin
            n = $urandom_range(1, 6);
            repeat (n)
               push_byte(8'($urandom_range(0, 255)));
         end else begin
            // Broken header: one or more first bytes, then a random byte.
            n = $urandom_range(1, 3);
            repeat (n)
               push_byte(HDR_FIRST);
            push_byte(8'($urandom_range(0, 255)));
         end
      end

      // Release reset.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (rx_stream.size() != 0 || req_tvalid)
         @(posedge clock);
      while (decoded_frames_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
